// ===== src/pser_pkg.sv =====
package pser_pkg;

    localparam int REG_INDEX_W = 3;

    localparam logic [REG_INDEX_W-1:0] REG_RATIO_UPPER    = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_RATIO_LOWER    = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_DC_LOW_FACTOR  = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_DC_HIGH_FACTOR = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_CLAMP_DELTA    = 3'd4;

    localparam logic [31:0] RATIO_ONE_Q30 = 32'h4000_0000;

    typedef struct packed {
        logic               is_dc;
        logic signed [31:0] base_real;
        logic signed [31:0] base_imag;
        logic signed [31:0] dev_real;
        logic signed [31:0] dev_imag;
        logic signed [31:0] edit_real;
        logic signed [31:0] edit_imag;
    } in_t;

    typedef struct packed {
        logic signed [31:0] new_dev_real;
        logic signed [31:0] new_dev_imag;
        logic signed [31:0] new_edit_real;
        logic signed [31:0] new_edit_imag;
        logic               changed;
    } out_t;

    typedef struct packed {
        logic        [31:0] ratio_upper;
        logic        [31:0] ratio_lower;
        logic signed [31:0] dc_low_factor;
        logic        [30:0] dc_high_factor;
        logic        [30:0] clamp_delta;
    } cfg_t;

endpackage

// ===== src/pser_core.sv =====
module pser_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  pser_pkg::in_t  in_data,
    input  pser_pkg::cfg_t cfg,
    output logic           out_valid,
    output pser_pkg::out_t out_data
);

    localparam int VW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int SH = 32 - VW;
    localparam logic signed [34:0] SAT_HI = (35'sd1 <<< (VW - 1)) - 35'sd1;
    localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;

    function automatic logic signed [31:0] sx(input logic [31:0] x);
        logic signed [31:0] t;
        t = $signed(x << SH);
        return t >>> SH;
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [34:0] v);
        logic signed [34:0] r;
        if (v > SAT_HI) r = SAT_HI;
        else if (v < SAT_LO) r = SAT_LO;
        else r = v;
        return r[31:0];
    endfunction

    // valid bits per stage
    logic [5:0] v_reg;

    // stage 1: sign extend, perturbed sums
    logic               s1_dc_reg;
    logic signed [31:0] s1_ore_reg, s1_oim_reg, s1_ere_reg, s1_eim_reg;
    logic signed [31:0] s1_dre_reg, s1_dim_reg;
    logic signed [32:0] s1_sre_reg, s1_sim_reg;

    // stage 2: squares, DC bounds, clamp compares
    logic               s2_dc_reg;
    logic signed [31:0] s2_ere_reg, s2_eim_reg, s2_dre_reg, s2_dim_reg;
    logic        [62:0] s2_qore_reg, s2_qoim_reg;
    logic        [64:0] s2_qsre_reg, s2_qsim_reg;
    logic signed [63:0] s2_dclo_reg, s2_dchi_reg;
    logic               s2_gtre_reg, s2_ltre_reg, s2_gtim_reg, s2_ltim_reg;

    // stage 3: powers, DC test
    logic               s3_dc_reg, s3_dcout_reg;
    logic signed [31:0] s3_ere_reg, s3_eim_reg, s3_dre_reg, s3_dim_reg;
    logic        [63:0] s3_p0_reg;
    logic        [65:0] s3_p1_reg;
    logic               s3_gtre_reg, s3_ltre_reg, s3_gtim_reg, s3_ltim_reg;

    // stage 4: ratio partial products
    logic               s4_dc_reg, s4_dcout_reg, s4_p0z_reg;
    logic signed [31:0] s4_ere_reg, s4_eim_reg, s4_dre_reg, s4_dim_reg;
    logic        [65:0] s4_p1_reg;
    logic        [63:0] s4_ulo_reg, s4_uhi_reg, s4_llo_reg, s4_lhi_reg;
    logic               s4_gtre_reg, s4_ltre_reg, s4_gtim_reg, s4_ltim_reg;

    // stage 5: band decision
    logic               s5_dc_reg, s5_fired_reg;
    logic signed [31:0] s5_ere_reg, s5_eim_reg, s5_dre_reg, s5_dim_reg;
    logic               s5_gtre_reg, s5_ltre_reg, s5_gtim_reg, s5_ltim_reg;

    // stage 6: output
    pser_pkg::out_t out_reg;

    logic signed [31:0] in_ore, in_oim, in_ere, in_eim;
    logic signed [65:0] sq_sre, sq_sim;
    logic signed [63:0] sq_ore, sq_oim;
    logic signed [32:0] dpos, dneg;
    logic signed [63:0] scaled;
    logic        [95:0] ru, rl, p1s;
    logic               in_band;
    logic signed [34:0] dp35, dn35;
    pser_pkg::out_t     res;

    assign in_ore = sx(in_data.base_real);
    assign in_oim = sx(in_data.base_imag);
    assign in_ere = sx(in_data.dev_real);
    assign in_eim = sx(in_data.dev_imag);

    assign sq_ore = s1_ore_reg * s1_ore_reg;
    assign sq_oim = s1_oim_reg * s1_oim_reg;
    assign sq_sre = s1_sre_reg * s1_sre_reg;
    assign sq_sim = s1_sim_reg * s1_sim_reg;
    assign dpos   = $signed({2'b00, cfg.clamp_delta});
    assign dneg   = -dpos;

    assign scaled = $signed({{2{s2_ere_reg[31]}}, s2_ere_reg, 30'b0});

    assign ru  = {s4_uhi_reg, 32'b0} + {32'b0, s4_ulo_reg};
    assign rl  = {s4_lhi_reg, 32'b0} + {32'b0, s4_llo_reg};
    assign p1s = {s4_p1_reg, 30'b0};
    assign in_band = !s4_p0z_reg && (p1s <= ru) && (p1s >= rl);

    assign dp35 = $signed({4'b0000, cfg.clamp_delta});
    assign dn35 = -dp35;

    always_comb
    begin
        res.new_dev_real  = s5_ere_reg;
        res.new_dev_imag  = s5_eim_reg;
        res.new_edit_real = s5_dre_reg;
        res.new_edit_imag = s5_dim_reg;
        res.changed       = s5_fired_reg;
        if (s5_fired_reg) begin
            if (s5_dc_reg) begin
                // move the whole real error into the edit
                res.new_edit_real = sat(35'(s5_dre_reg) - 35'(s5_ere_reg));
                res.new_dev_real  = '0;
            end
            else begin
                if (s5_gtre_reg) begin
                    res.new_edit_real = sat(35'(s5_dre_reg) + dp35 - 35'(s5_ere_reg));
                    res.new_dev_real  = dp35[31:0];
                end
                else if (s5_ltre_reg) begin
                    res.new_edit_real = sat(35'(s5_dre_reg) + dn35 - 35'(s5_ere_reg));
                    res.new_dev_real  = dn35[31:0];
                end
                if (s5_gtim_reg) begin
                    res.new_edit_imag = sat(35'(s5_dim_reg) + dp35 - 35'(s5_eim_reg));
                    res.new_dev_imag  = dp35[31:0];
                end
                else if (s5_ltim_reg) begin
                    res.new_edit_imag = sat(35'(s5_dim_reg) + dn35 - 35'(s5_eim_reg));
                    res.new_dev_imag  = dn35[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s1_dc_reg  <= in_data.is_dc;
            s1_ore_reg <= in_ore;
            s1_oim_reg <= in_oim;
            s1_ere_reg <= in_ere;
            s1_eim_reg <= in_eim;
            s1_dre_reg <= sx(in_data.edit_real);
            s1_dim_reg <= sx(in_data.edit_imag);
            s1_sre_reg <= 33'(in_ore) + 33'(in_ere);
            s1_sim_reg <= 33'(in_oim) + 33'(in_eim);

            s2_dc_reg   <= s1_dc_reg;
            s2_ere_reg  <= s1_ere_reg;
            s2_eim_reg  <= s1_eim_reg;
            s2_dre_reg  <= s1_dre_reg;
            s2_dim_reg  <= s1_dim_reg;
            s2_qore_reg <= sq_ore[62:0];
            s2_qoim_reg <= sq_oim[62:0];
            s2_qsre_reg <= sq_sre[64:0];
            s2_qsim_reg <= sq_sim[64:0];
            s2_dclo_reg <= s1_ore_reg * cfg.dc_low_factor;
            s2_dchi_reg <= s1_ore_reg * $signed({1'b0, cfg.dc_high_factor});
            s2_gtre_reg <= 33'(s1_ere_reg) > dpos;
            s2_ltre_reg <= 33'(s1_ere_reg) < dneg;
            s2_gtim_reg <= 33'(s1_eim_reg) > dpos;
            s2_ltim_reg <= 33'(s1_eim_reg) < dneg;

            s3_dc_reg    <= s2_dc_reg;
            s3_dcout_reg <= (scaled > s2_dchi_reg) || (scaled < s2_dclo_reg);
            s3_ere_reg   <= s2_ere_reg;
            s3_eim_reg   <= s2_eim_reg;
            s3_dre_reg   <= s2_dre_reg;
            s3_dim_reg   <= s2_dim_reg;
            s3_p0_reg    <= 64'(s2_qore_reg) + 64'(s2_qoim_reg);
            s3_p1_reg    <= 66'(s2_qsre_reg) + 66'(s2_qsim_reg);
            s3_gtre_reg  <= s2_gtre_reg;
            s3_ltre_reg  <= s2_ltre_reg;
            s3_gtim_reg  <= s2_gtim_reg;
            s3_ltim_reg  <= s2_ltim_reg;

            s4_dc_reg    <= s3_dc_reg;
            s4_dcout_reg <= s3_dcout_reg;
            s4_p0z_reg   <= (s3_p0_reg == '0);
            s4_ere_reg   <= s3_ere_reg;
            s4_eim_reg   <= s3_eim_reg;
            s4_dre_reg   <= s3_dre_reg;
            s4_dim_reg   <= s3_dim_reg;
            s4_p1_reg    <= s3_p1_reg;
            s4_ulo_reg   <= cfg.ratio_upper * s3_p0_reg[31:0];
            s4_uhi_reg   <= cfg.ratio_upper * s3_p0_reg[63:32];
            s4_llo_reg   <= cfg.ratio_lower * s3_p0_reg[31:0];
            s4_lhi_reg   <= cfg.ratio_lower * s3_p0_reg[63:32];
            s4_gtre_reg  <= s3_gtre_reg;
            s4_ltre_reg  <= s3_ltre_reg;
            s4_gtim_reg  <= s3_gtim_reg;
            s4_ltim_reg  <= s3_ltim_reg;

            s5_dc_reg    <= s4_dc_reg;
            s5_fired_reg <= s4_dc_reg ? s4_dcout_reg : !in_band;
            s5_ere_reg   <= s4_ere_reg;
            s5_eim_reg   <= s4_eim_reg;
            s5_dre_reg   <= s4_dre_reg;
            s5_dim_reg   <= s4_dim_reg;
            s5_gtre_reg  <= s4_gtre_reg;
            s5_ltre_reg  <= s4_ltre_reg;
            s5_gtim_reg  <= s4_gtim_reg;
            s5_ltim_reg  <= s4_ltim_reg;

            out_reg <= res;
        end
    end

    assign out_valid = v_reg[5];
    assign out_data  = out_reg;

endmodule

// ===== src/pointwise_spectral_error_projection.sv =====
// Pointwise spectral error projection, one frequency bin per transfer.
// Input channel: in_valid / in_stall / in_data carry one bin (DC flag,
// original, error and edit values, Q16.16). Output channel: out_valid /
// out_stall / out_data carry the projected error, updated edits and the
// changed flag. Registers are written through wr_en / wr_index / wr_data;
// write them only while no bin is in flight (the block does not enforce
// this); writes to unused indexes are dropped. One bin is taken every
// cycle while in_stall is low; the six-stage datapath advances as a whole
// whenever the output register is empty or being taken.
// The ratio test splits the 32x64 bound products into two 32x32 halves
// in one stage and adds and compares them in the next.
// When the receiver holds out_stall with a result waiting, every stage
// holds and in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with their defaults
// (both ratio bounds 1.0, the other registers zero).
module pointwise_spectral_error_projection #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  pser_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output pser_pkg::out_t                     out_data,
    input  logic                               wr_en,
    input  logic [pser_pkg::REG_INDEX_W-1:0]   wr_index,
    input  logic [31:0]                        wr_data
);

    pser_pkg::cfg_t cfg_reg;
    logic           en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.ratio_upper    <= pser_pkg::RATIO_ONE_Q30;
            cfg_reg.ratio_lower    <= pser_pkg::RATIO_ONE_Q30;
            cfg_reg.dc_low_factor  <= '0;
            cfg_reg.dc_high_factor <= '0;
            cfg_reg.clamp_delta    <= '0;
        end
        else if (wr_en) begin
            unique case (wr_index)
                pser_pkg::REG_RATIO_UPPER:    cfg_reg.ratio_upper    <= wr_data;
                pser_pkg::REG_RATIO_LOWER:    cfg_reg.ratio_lower    <= wr_data;
                pser_pkg::REG_DC_LOW_FACTOR:  cfg_reg.dc_low_factor  <= $signed(wr_data);
                pser_pkg::REG_DC_HIGH_FACTOR: cfg_reg.dc_high_factor <= wr_data[30:0];
                pser_pkg::REG_CLAMP_DELTA:    cfg_reg.clamp_delta    <= wr_data[30:0];
                default: ;
            endcase
        end
    end

    // advance the whole pipe unless a finished result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    pser_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .out_valid(out_valid),
        .out_data (out_data)
    );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDX_W = pser_pkg::REG_INDEX_W;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    pser_pkg::in_t in_data;
    logic out_valid;
    logic out_stall;
    pser_pkg::out_t out_data;
    logic wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [31:0] wr_data;

    pointwise_spectral_error_projection dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data)
    );

    // shadow copy of the register file
    logic [31:0] bound_upper;
    logic [31:0] bound_lower;
    longint dc_low;
    longint dc_high;
    longint clamp_lim;

    pser_pkg::in_t pending_bins[$];
    pser_pkg::out_t expected_bins[$];

    logic in_taken;
    logic out_taken;
    int gap_left;
    bit gap_burst;
    int stall_left;
    int hold_left;
    int hold_requests;
    int holds_served;
    int mismatches;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint sat_edit(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void clamp_part(inout longint e, inout longint ed);
        if (e > clamp_lim)
        begin
            ed = sat_edit(ed + (clamp_lim - e));
            e = clamp_lim;
        end
        else if (e < -clamp_lim)
        begin
            ed = sat_edit(ed + (-clamp_lim - e));
            e = -clamp_lim;
        end
    endfunction

    function automatic logic [127:0] bin_power(longint re, longint im);
        logic [127:0] a;
        logic [127:0] b;
        a = (re < 0) ? -re : re;
        b = (im < 0) ? -im : im;
        return a * a + b * b;
    endfunction

    function automatic pser_pkg::out_t project_bin(pser_pkg::in_t x);
        longint o_re;
        longint o_im;
        longint e_re;
        longint e_im;
        longint d_re;
        longint d_im;
        logic [127:0] p0;
        logic [127:0] p1;
        logic [127:0] up_lim;
        logic [127:0] lo_lim;
        bit fired;
        pser_pkg::out_t r;
        o_re = x.base_real;
        o_im = x.base_imag;
        e_re = x.dev_real;
        e_im = x.dev_imag;
        d_re = x.edit_real;
        d_im = x.edit_imag;
        fired = 1'b0;
        if (x.is_dc)
        begin
            if (e_re * 64'sd1073741824 > o_re * dc_high ||
                e_re * 64'sd1073741824 < o_re * dc_low)
            begin
                fired = 1'b1;
                d_re = sat_edit(d_re - e_re);
                e_re = 0;
            end
        end
        else
        begin
            p0 = bin_power(o_re, o_im);
            p1 = bin_power(o_re + e_re, o_im + e_im) << 30;
            up_lim = {96'd0, bound_upper} * p0;
            lo_lim = {96'd0, bound_lower} * p0;
            if (p0 == 0 || p1 > up_lim || p1 < lo_lim)
            begin
                fired = 1'b1;
                clamp_part(e_re, d_re);
                clamp_part(e_im, d_im);
            end
        end
        r.new_dev_real = e_re[31:0];
        r.new_dev_imag = e_im[31:0];
        r.new_edit_real = d_re[31:0];
        r.new_edit_imag = d_im[31:0];
        r.changed = fired;
        return r;
    endfunction

    // input transfer and result check
    always @(posedge clk)
    begin
        pser_pkg::out_t got;
        pser_pkg::out_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            out_taken <= out_valid && !out_stall;
            if (in_valid && !in_stall)
                expected_bins.push_back(project_bin(in_data));
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (expected_bins.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_bins.pop_front();
                    if (got.new_dev_real !== want.new_dev_real ||
                        got.new_dev_imag !== want.new_dev_imag ||
                        got.new_edit_real !== want.new_edit_real ||
                        got.new_edit_imag !== want.new_edit_imag ||
                        got.changed !== want.changed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected err %h %h edit %h %h chg %b,",
                                      " got err %h %h edit %h %h chg %b"},
                                want.new_dev_real, want.new_dev_imag, want.new_edit_real,
                                want.new_edit_imag, want.changed, got.new_dev_real,
                                got.new_dev_imag, got.new_edit_real, got.new_edit_imag,
                                got.changed);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_bins.size() > 0)
            begin
                in_data <= pending_bins.pop_front();
                in_valid <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    gap_burst = !gap_burst;
                gap_left <= gap_burst ? 0 : $urandom_range(0, 16);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        int s;
        int h;
        if (rst_n)
        begin
            s = stall_left;
            h = hold_left;
            if (out_taken)
                s = gap_burst ? 0 : $urandom_range(0, 16);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                h = LONG_HOLD;
            end
            if (h > 0)
            begin
                h--;
                out_stall <= 1'b1;
            end
            else if (s > 0)
            begin
                s--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
            stall_left = s;
            hold_left = h;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] v);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= v;
        case (idx)
            pser_pkg::REG_RATIO_UPPER: bound_upper = v;
            pser_pkg::REG_RATIO_LOWER: bound_lower = v;
            pser_pkg::REG_DC_LOW_FACTOR: dc_low = longint'($signed(v));
            pser_pkg::REG_DC_HIGH_FACTOR: dc_high = longint'(v[30:0]);
            pser_pkg::REG_CLAMP_DELTA: clamp_lim = longint'(v[30:0]);
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] up, input logic [31:0] lo,
                             input logic [31:0] dlo, input logic [31:0] dhi,
                             input logic [31:0] cl);
        write_reg(pser_pkg::REG_RATIO_UPPER, up);
        write_reg(pser_pkg::REG_RATIO_LOWER, lo);
        write_reg(pser_pkg::REG_DC_LOW_FACTOR, dlo);
        write_reg(pser_pkg::REG_DC_HIGH_FACTOR, dhi);
        write_reg(pser_pkg::REG_CLAMP_DELTA, cl);
        // unused indexes must be dropped
        write_reg(IDX_W'(5 + $urandom_range(0, 2)), $urandom);
    endtask

    task automatic wait_drained();
        while (pending_bins.size() > 0 || in_valid || expected_bins.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return $urandom_range(0, 3) - 1;
            4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom;
        endcase
    endfunction

    // error that keeps the perturbed bin near the original's power
    function automatic logic [31:0] near_error(logic signed [31:0] o);
        logic signed [31:0] e;
        e = o >>> $urandom_range(1, 8);
        if ($urandom_range(0, 1))
            e = -e;
        return e + $signed($urandom_range(0, 255)) - 128;
    endfunction

    function automatic pser_pkg::in_t random_bin();
        pser_pkg::in_t x;
        x.is_dc = ($urandom_range(0, 5) == 0);
        x.base_real = pick_value();
        x.base_imag = pick_value();
        x.edit_real = pick_value();
        x.edit_imag = pick_value();
        if ($urandom_range(0, 2) != 0)
        begin
            x.dev_real = near_error(x.base_real);
            x.dev_imag = near_error(x.base_imag);
        end
        else
        begin
            x.dev_real = pick_value();
            x.dev_imag = pick_value();
        end
        return x;
    endfunction

    function automatic pser_pkg::in_t make_bin(bit dc, logic [31:0] ore, logic [31:0] oim,
                                               logic [31:0] ere, logic [31:0] eim,
                                               logic [31:0] dre, logic [31:0] dim);
        pser_pkg::in_t x;
        x.is_dc = dc;
        x.base_real = ore;
        x.base_imag = oim;
        x.dev_real = ere;
        x.dev_imag = eim;
        x.edit_real = dre;
        x.edit_imag = dim;
        return x;
    endfunction

    task automatic random_phase(int n);
        repeat (n) pending_bins.push_back(random_bin());
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        in_taken = 1'b0;
        out_taken = 1'b0;
        gap_left = 0;
        gap_burst = 1'b0;
        stall_left = 0;
        hold_left = 0;
        hold_requests = 0;
        holds_served = 0;
        mismatches = 0;
        idle_cycles = 0;
        bound_upper = pser_pkg::RATIO_ONE_Q30;
        bound_lower = pser_pkg::RATIO_ONE_Q30;
        dc_low = 0;
        dc_high = 0;
        clamp_lim = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults first
        random_phase(120);

        write_all(32'h5000_0000, 32'h3000_0000, 32'he000_0000, 32'h2000_0000,
                  32'h0001_0000);
        pending_bins.push_back(make_bin(0, 0, 0, 32'h10, 32'hffff_fff0, 5, 6));
        pending_bins.push_back(make_bin(0, 0, 0, 0, 0, 0, 0));
        pending_bins.push_back(make_bin(0, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000));
        pending_bins.push_back(make_bin(0, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h7fff_ffff, 32'h7fff_ffff));
        pending_bins.push_back(make_bin(0, 32'h0001_0000, 0, 32'h8000_0000, 0,
                                        32'h7fff_ff00, 0));
        pending_bins.push_back(make_bin(0, 32'h0001_0000, 0, 32'h7fff_ffff, 0,
                                        32'h8000_0100, 0));
        pending_bins.push_back(make_bin(0, 32'h0001_0000, 32'h0001_0000, 32'h100, 32'h100,
                                        1, 2));
        pending_bins.push_back(make_bin(0, 32'h0002_0000, 0, 32'h0000_3000, 0, 0, 0));
        pending_bins.push_back(make_bin(0, 32'h0002_0000, 0, 32'hffff_c000, 0, 0, 0));
        pending_bins.push_back(make_bin(1, 32'h0001_0000, 32'h1234, 32'h0000_8000, 32'h55,
                                        0, 32'h77));
        pending_bins.push_back(make_bin(1, 32'h0001_0000, 0, 32'h0000_8001, 0, 0, 0));
        pending_bins.push_back(make_bin(1, 32'h0001_0000, 0, 32'hffff_8000, 0, 0, 0));
        pending_bins.push_back(make_bin(1, 32'h0001_0000, 0, 32'hffff_7fff, 0, 9, 0));
        pending_bins.push_back(make_bin(1, 32'hffff_0000, 0, 0, 0, 3, 0));
        pending_bins.push_back(make_bin(1, 32'hffff_0000, 0, 32'h10, 0, 3, 0));
        pending_bins.push_back(make_bin(1, 0, 32'h7fff_ffff, 0, 32'h8000_0000, 0,
                                        32'h8000_0000));
        pending_bins.push_back(make_bin(1, 32'h0001_0000, 0, 32'h7fff_ffff, 0,
                                        32'h8000_0000, 0));
        pending_bins.push_back(make_bin(1, 32'h0001_0000, 0, 32'h8000_0000, 0,
                                        32'h7fff_ffff, 0));
        pending_bins.push_back(make_bin(1, 32'h8000_0000, 0, 32'h8000_0000, 0,
                                        32'h7fff_ffff, 0));
        // block the receiver while the sender keeps offering bins
        hold_requests++;
        random_phase(180);

        write_all(32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h7fff_ffff);
        random_phase(180);

        write_all(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000);
        random_phase(150);

        write_all(32'h4000_0000 + $urandom_range(0, 32'h1000_0000),
                  32'h4000_0000 - $urandom_range(0, 32'h1000_0000),
                  -$urandom_range(0, 32'h8000_0000), $urandom_range(0, 32'h7fff_ffff),
                  $urandom_range(0, 32'h0010_0000));
        hold_requests++;
        random_phase(250);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
